FILE: rtl/iacab_pkg.sv
// Shared types and constants for the inverted-alpha ARGB blend pipeline.
package iacab_pkg;

   localparam int unsigned CH_W = 8;
   localparam int unsigned PIX_W = 32;

   // Saturation ceiling of one channel, inverted alpha of a transparent pixel.
   localparam logic [CH_W-1:0] CH_MAX = 8'hff;
   // Unity in the 1.8 fixed-point scaling used by all the products.
   localparam logic [CH_W:0] UNITY = 9'h100;

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [CH_W:0]    scale_type;
   typedef logic [PIX_W-1:0] pixel_type;

   // Extract one byte of a pixel, its inverted alpha or a colour byte, chosen by sel.
   function automatic chan_type pix_byte(input pixel_type pix, input logic [1:0] sel);
      chan_type res;
      res = pix[sel*CH_W +: CH_W];
      return res;
   endfunction

   localparam logic [1:0] BYTE_B = 2'd0;
   localparam logic [1:0] BYTE_G = 2'd1;
   localparam logic [1:0] BYTE_R = 2'd2;
   localparam logic [1:0] BYTE_A = 2'd3;

endpackage

FILE: rtl/inverted_alpha_coloralpha_blend_top.sv
// Four-stage source-over blend of inverted-alpha ARGB pixels with a global colour alpha.
//
// One pixel pair is taken per clock while req_stall is low. The four register
// stages are: input capture with the opacity factor, source scaling (three
// channel products and the effective alpha), destination scaling (four
// products), then add, saturate and alpha repack. Every stage holds its own
// valid bit and advances whenever it is empty or the stage after it moves, so
// bubbles are squeezed out and req_stall rises only when all four stages are
// full and the result side stalls. The colour alpha register resets to 255 and
// is written through the csr_ port, which is always ready; write it only while
// no beat is in flight. A zero colour alpha or a source alpha byte of 255
// passes the destination through with rsp_write_enable low.
module inverted_alpha_coloralpha_blend_top
   import iacab_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  pixel_type  req_src_pixel,
   input  pixel_type  req_dst_pixel,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output pixel_type  rsp_out_pixel,
   output logic       rsp_write_enable,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  chan_type   csr_color_alpha
);

   chan_type color_alpha_ff;

   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;

   // stage 1
   pixel_type s1_src_ff, s1_dst_ff;
   scale_type s1_f_ff;
   logic      s1_skip_ff;
   logic      s1_skip_in;

   // stage 2
   pixel_type s2_dst_ff;
   scale_type s2_ap_ff;
   chan_type  s2_sr_ff, s2_sg_ff, s2_sb_ff;
   logic      s2_skip_ff;
   scale_type s2_ap_in;
   chan_type  s2_sr_in, s2_sg_in, s2_sb_in;
   logic [16:0] s2_pa;
   logic [16:0] s2_pr, s2_pg, s2_pb;

   // stage 3
   pixel_type s3_dst_ff;
   scale_type s3_ap_ff;
   chan_type  s3_sr_ff, s3_sg_ff, s3_sb_ff;
   chan_type  s3_dr_ff, s3_dg_ff, s3_db_ff;
   scale_type s3_t_ff;
   logic      s3_skip_ff;
   logic [17:0] s3_pr, s3_pg, s3_pb, s3_pa;
   chan_type  s3_dr_in, s3_dg_in, s3_db_in;
   scale_type s3_t_in;

   // stage 4
   pixel_type s4_pix_ff;
   logic      s4_we_ff;
   pixel_type s4_pix_in;
   logic [CH_W+1:0] s4_cov;
   chan_type  s4_ao, s4_r, s4_g, s4_b;
   logic [CH_W:0] s4_sum_r, s4_sum_g, s4_sum_b;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_alpha_ff <= CH_MAX;
      end else if (csr_valid && csr_ready) begin
         color_alpha_ff <= csr_color_alpha;
      end
   end

   // A stage moves when it is empty or its successor moves.
   assign en4 = !s4_valid_ff || !rsp_stall;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         if (en4) s4_valid_ff <= s3_valid_ff;
      end
   end

   // Stage 1: capture, opacity factor and pass-through decision.
   assign s1_skip_in = (color_alpha_ff == '0) || (pix_byte(req_src_pixel, BYTE_A) == CH_MAX);

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_src_ff  <= req_src_pixel;
         s1_dst_ff  <= req_dst_pixel;
         s1_f_ff    <= {1'b0, color_alpha_ff} + scale_type'(1);
         s1_skip_ff <= s1_skip_in;
      end
   end

   // Stage 2: scale the source by F.
   always_comb begin
      s2_pa = 17'(s1_f_ff) * 17'(UNITY - {1'b0, pix_byte(s1_src_ff, BYTE_A)});
      s2_pr = 17'(s1_f_ff) * 17'(pix_byte(s1_src_ff, BYTE_R));
      s2_pg = 17'(s1_f_ff) * 17'(pix_byte(s1_src_ff, BYTE_G));
      s2_pb = 17'(s1_f_ff) * 17'(pix_byte(s1_src_ff, BYTE_B));
      s2_ap_in = UNITY - s2_pa[16:8];
      s2_sr_in = s2_pr[15:8];
      s2_sg_in = s2_pg[15:8];
      s2_sb_in = s2_pb[15:8];
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_dst_ff  <= s1_dst_ff;
         s2_ap_ff   <= s2_ap_in;
         s2_sr_ff   <= s2_sr_in;
         s2_sg_ff   <= s2_sg_in;
         s2_sb_ff   <= s2_sb_in;
         s2_skip_ff <= s1_skip_ff;
      end
   end

   // Stage 3: scale the destination by the effective inverted alpha.
   always_comb begin
      s3_pr = 18'(s2_ap_ff) * 18'(pix_byte(s2_dst_ff, BYTE_R));
      s3_pg = 18'(s2_ap_ff) * 18'(pix_byte(s2_dst_ff, BYTE_G));
      s3_pb = 18'(s2_ap_ff) * 18'(pix_byte(s2_dst_ff, BYTE_B));
      s3_pa = 18'(s2_ap_ff) * 18'(UNITY - {1'b0, pix_byte(s2_dst_ff, BYTE_A)});
      s3_dr_in = s3_pr[15:8];
      s3_dg_in = s3_pg[15:8];
      s3_db_in = s3_pb[15:8];
      s3_t_in  = s3_pa[16:8];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_dst_ff  <= s2_dst_ff;
         s3_ap_ff   <= s2_ap_ff;
         s3_sr_ff   <= s2_sr_ff;
         s3_sg_ff   <= s2_sg_ff;
         s3_sb_ff   <= s2_sb_ff;
         s3_dr_ff   <= s3_dr_in;
         s3_dg_ff   <= s3_dg_in;
         s3_db_ff   <= s3_db_in;
         s3_t_ff    <= s3_t_in;
         s3_skip_ff <= s2_skip_ff;
      end
   end

   // Stage 4: add, saturate, repack the coverage as an inverted alpha.
   always_comb begin
      s4_sum_r = {1'b0, s3_dr_ff} + {1'b0, s3_sr_ff};
      s4_sum_g = {1'b0, s3_dg_ff} + {1'b0, s3_sg_ff};
      s4_sum_b = {1'b0, s3_db_ff} + {1'b0, s3_sb_ff};
      s4_r = s4_sum_r[CH_W] ? CH_MAX : s4_sum_r[CH_W-1:0];
      s4_g = s4_sum_g[CH_W] ? CH_MAX : s4_sum_g[CH_W-1:0];
      s4_b = s4_sum_b[CH_W] ? CH_MAX : s4_sum_b[CH_W-1:0];
      s4_cov = {1'b0, s3_t_ff} + {1'b0, UNITY} - {1'b0, s3_ap_ff};
      // full coverage wraps to an opaque zero
      if (s4_cov >= {1'b0, UNITY}) begin
         s4_ao = '0;
      end else begin
         s4_ao = s4_cov[CH_W-1:0] == '0 ? '0 : CH_W'(10'(UNITY) - s4_cov);
      end
      s4_pix_in = s3_skip_ff ? s3_dst_ff : {s4_ao, s4_r, s4_g, s4_b};
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_pix_ff <= s4_pix_in;
         s4_we_ff  <= !s3_skip_ff;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_out_pixel    = s4_pix_ff;
   assign rsp_write_enable = s4_we_ff;

   // Input back-pressure only when the whole pipe is full and blocked.
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s3_valid_ff && s4_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline has room");

   // An accepted beat always lands in the first stage.
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_valid_ff)
      else $error("accepted beat lost at stage 1");

   // Effective inverted alpha never exceeds unity.
   a_ap_range : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_ap_ff <= UNITY))
      else $error("effective alpha out of range");

   // Destination coverage term is bounded by the alpha that scaled it.
   a_cov_bound : assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> (s3_t_ff <= s3_ap_ff))
      else $error("coverage term exceeds effective alpha");

endmodule
